// ===== hw/rtl/gamma_contrast_brightness_unit_defines.svh =====
// ----------------------------------------------------------------------------
// gamma_contrast_brightness_unit assertion macros
// Shared concurrent assertion forms for the checker of the adjustment unit.
// ----------------------------------------------------------------------------
`ifndef GAMMA_CONTRAST_BRIGHTNESS_UNIT_DEFINES_SVH
`define GAMMA_CONTRAST_BRIGHTNESS_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define GCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gcb check failed");

// Check a property on every clock edge, reset included.
`define GCB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gcb check failed");

`endif

// ===== hw/rtl/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// Types, register codes, fixed-point constants and the root table function.
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

  // Control that travels with every pipeline beat
  typedef struct packed {
    logic vld;
    logic zero;
  } gcb_ctl_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    GCB_REG_GAMMA    = 2'd0,
    GCB_REG_CONTRAST = 2'd1,
    GCB_REG_BRIGHT   = 2'd2,
    GCB_REG_MAXIMUM  = 2'd3
  } gcb_reg_t;

  localparam int GCB_FRAC_BITS = 24;
  localparam int GCB_LOG_W     = 29;
  localparam int GCB_LATENCY   = 56;

  localparam logic [31:0]        GCB_ROOT_ONE = 32'h4000_0000;
  localparam logic [45:0]        GCB_P_LIMIT  = 46'h2000_0000_0000;
  localparam logic signed [63:0] GCB_V_ONE    = 64'sh0000_0400_0000_0000;

  // Truncating integer square root, elaboration only
  function automatic logic [63:0] gcb_isqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q.30, built by repeated roots from 2.0
  function automatic logic [31:0] gcb_root(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= k; i++) r = gcb_isqrt(r << 30);
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gcb_log2.sv =====
// ----------------------------------------------------------------------------
// gcb_log2
// Two-lane pipelined log2 in Q.24: normalize, then one squaring per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_log2 import gcb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gcb_ctl_t             in_ctl,
  input  wire logic [31:0]          in_a,
  input  wire logic [31:0]          in_b,
  output gcb_ctl_t                  out_ctl,
  output logic [GCB_LOG_W-1:0]      out_la,
  output logic [GCB_LOG_W-1:0]      out_lb
);

  localparam int STEPS = GCB_FRAC_BITS;

  gcb_ctl_t                 ctl_r [0:STEPS];
  logic [31:0]              z_r   [0:STEPS][0:1];
  logic [4:0]               e_r   [0:STEPS][0:1];
  logic [GCB_FRAC_BITS-1:0] fr_r  [0:STEPS][0:1];

  // Advance control through every stage; clear only the valid bits in reset
  always_ff @(posedge clk) begin
    ctl_r[0].zero <= in_ctl.zero;
    for (int s = 1; s <= STEPS; s++) ctl_r[s].zero <= ctl_r[s-1].zero;
    if (!rst_n) begin
      for (int s = 0; s <= STEPS; s++) ctl_r[s].vld <= 1'b0;
    end else begin
      ctl_r[0].vld <= in_ctl.vld;
      for (int s = 1; s <= STEPS; s++) ctl_r[s].vld <= ctl_r[s-1].vld;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] val;
    logic [4:0]  e_nxt;
    logic [31:0] z_nxt;

    assign val = (l == 0) ? in_a : in_b;

    // Find the leading one and normalize to Q1.31
    always_comb begin
      e_nxt = '0;
      for (int i = 0; i < 32; i++) if (val[i]) e_nxt = 5'(i);
      z_nxt = val << (5'd31 - e_nxt);
    end

    always_ff @(posedge clk) begin
      z_r[0][l]  <= z_nxt;
      e_r[0][l]  <= e_nxt;
      fr_r[0][l] <= '0;
    end

    // Square, take one fraction bit, renormalize
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [63:0] sq;
      logic [32:0] t;
      always_comb begin
        sq = 64'(z_r[k-1][l]) * 64'(z_r[k-1][l]);
        t  = sq[63:31];
      end
      always_ff @(posedge clk) begin
        z_r[k][l]  <= t[32] ? t[32:1] : t[31:0];
        e_r[k][l]  <= e_r[k-1][l];
        fr_r[k][l] <= {fr_r[k-1][l][GCB_FRAC_BITS-2:0], t[32]};
      end
    end
  end

  assign out_ctl = ctl_r[STEPS];
  assign out_la  = {e_r[STEPS][0], fr_r[STEPS][0]};
  assign out_lb  = {e_r[STEPS][1], fr_r[STEPS][1]};

endmodule

`default_nettype wire

// ===== hw/rtl/gcb_exp2.sv =====
// ----------------------------------------------------------------------------
// gcb_exp2
// Pipelined exp2 of a Q.24 fraction: one conditional root product per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_exp2 import gcb_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire gcb_ctl_t                 in_ctl,
  input  wire logic signed [11:0]       in_n,
  input  wire logic [GCB_FRAC_BITS-1:0] in_f,
  output gcb_ctl_t                      out_ctl,
  output logic signed [11:0]            out_n,
  output logic [31:0]                   out_acc
);

  localparam int STEPS = GCB_FRAC_BITS;

  gcb_ctl_t                 ctl_r [1:STEPS];
  logic signed [11:0]       n_r   [1:STEPS];
  logic [GCB_FRAC_BITS-1:0] f_r   [1:STEPS];
  logic [31:0]              acc_r [1:STEPS];

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam logic [31:0] ROOT = gcb_root(k);

    gcb_ctl_t                 src_ctl;
    logic signed [11:0]       src_n;
    logic [GCB_FRAC_BITS-1:0] src_f;
    logic [31:0]              src_acc;
    logic [63:0]              mul;

    if (k == 1) begin : g_first
      assign src_ctl = in_ctl;
      assign src_n   = in_n;
      assign src_f   = in_f;
      assign src_acc = GCB_ROOT_ONE;
    end else begin : g_next
      assign src_ctl = ctl_r[k-1];
      assign src_n   = n_r[k-1];
      assign src_f   = f_r[k-1];
      assign src_acc = acc_r[k-1];
    end

    // Multiply in the root where its fraction bit is set
    assign mul = 64'(src_acc) * 64'(ROOT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].vld <= 1'b0;
      end else begin
        ctl_r[k].vld <= src_ctl.vld;
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[k].zero <= src_ctl.zero;
      n_r[k]        <= src_n;
      f_r[k]        <= src_f;
      acc_r[k]      <= src_f[STEPS-k] ? mul[61:30] : src_acc;
    end
  end

  assign out_ctl = ctl_r[STEPS];
  assign out_n   = n_r[STEPS];
  assign out_acc = acc_r[STEPS];

endmodule

`default_nettype wire

// ===== hw/rtl/gamma_contrast_brightness_unit.sv =====
// ----------------------------------------------------------------------------
// gamma_contrast_brightness_unit
// Per-sample gamma, contrast and brightness adjustment, fully pipelined.
// ----------------------------------------------------------------------------
// One sample enters per clock while busy is low (busy is high only in reset).
// Each sample's result leaves marked by a one-cycle out_strobe; the
// receiver cannot hold results, and none is ever dropped. The pipeline
// holds the log2 chain (one normalize stage and 24 squaring stages), the
// 24-stage exp2 root product chain, and seven stages of exponent, scaling,
// rounding and output registers. Configuration writes take effect at once
// and belong to times when no sample is in flight.
`default_nettype none

module gamma_contrast_brightness_unit import gcb_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_in,
  output logic                        out_strobe,
  output logic [SAMPLE_BITS-1:0]      out_sample_out,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);

  // Configuration registers
  logic [15:0]        gamma_r;
  logic signed [13:0] contrast_r;
  logic signed [13:0] bright_r;
  logic [15:0]        max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r    <= 16'd4096;
      contrast_r <= '0;
      bright_r   <= '0;
      max_r      <= 16'd255;
    end else if (cfg_we) begin
      unique case (gcb_reg_t'(cfg_index))
        GCB_REG_GAMMA:    gamma_r    <= cfg_data;
        GCB_REG_CONTRAST: contrast_r <= cfg_data[13:0];
        GCB_REG_BRIGHT:   bright_r   <= cfg_data[13:0];
        GCB_REG_MAXIMUM:  max_r      <= cfg_data;
      endcase
    end
  end

  assign busy = ~rst_n;

  // Log2 of sample and maximum
  gcb_ctl_t              in_ctl;
  gcb_ctl_t              l_ctl;
  logic [GCB_LOG_W-1:0]  l_ls;
  logic [GCB_LOG_W-1:0]  l_lm;

  assign in_ctl.vld  = start & ~busy;
  assign in_ctl.zero = (in_sample_in == '0);

  gcb_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (in_ctl),
    .in_a    (32'(in_sample_in)),
    .in_b    (32'(max_r)),
    .out_ctl (l_ctl),
    .out_la  (l_ls),
    .out_lb  (l_lm)
  );

  // Stage A: log difference and direction
  gcb_ctl_t             a_ctl_r;
  logic                 a_up_r;
  logic [GCB_LOG_W-1:0] a_d_r;

  // Stage B: scale by gamma, round half up
  gcb_ctl_t    b_ctl_r;
  logic        b_up_r;
  logic [33:0] b_p_r;
  logic [45:0] b_pg;

  // Stage C: integer and fraction of the exponent
  gcb_ctl_t                 c_ctl_r;
  logic signed [11:0]       c_n_r;
  logic [GCB_FRAC_BITS-1:0] c_f_r;
  logic signed [11:0]       c_n_nxt;
  logic [GCB_FRAC_BITS-1:0] c_f_nxt;
  logic [9:0]               c_ip;
  logic [GCB_FRAC_BITS-1:0] c_fr;

  assign b_pg = 46'(a_d_r) * 46'(gamma_r) + 46'd2048;
  assign c_ip = b_p_r[33:24];
  assign c_fr = b_p_r[23:0];

  always_comb begin
    if (b_up_r) begin
      c_n_nxt = signed'(12'(c_ip));
      c_f_nxt = c_fr;
    end else if (c_fr == '0) begin
      c_n_nxt = -signed'(12'(c_ip));
      c_f_nxt = '0;
    end else begin
      c_n_nxt = -signed'(12'(c_ip)) - 12'sd1;
      c_f_nxt = 24'(25'h100_0000 - 25'(c_fr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r.vld <= 1'b0;
      b_ctl_r.vld <= 1'b0;
      c_ctl_r.vld <= 1'b0;
    end else begin
      a_ctl_r.vld <= l_ctl.vld;
      b_ctl_r.vld <= a_ctl_r.vld;
      c_ctl_r.vld <= b_ctl_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ctl_r.zero <= l_ctl.zero;
    a_up_r       <= l_ls > l_lm;
    a_d_r        <= (l_ls > l_lm) ? l_ls - l_lm : l_lm - l_ls;
    b_ctl_r.zero <= a_ctl_r.zero;
    b_up_r       <= a_up_r;
    b_p_r        <= b_pg[45:12];
    c_ctl_r.zero <= b_ctl_r.zero;
    c_n_r        <= c_n_nxt;
    c_f_r        <= c_f_nxt;
  end

  // Exp2 of the fraction
  gcb_ctl_t           x_ctl;
  logic signed [11:0] x_n;
  logic [31:0]        x_acc;

  gcb_exp2 u_exp2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (c_ctl_r),
    .in_n    (c_n_r),
    .in_f    (c_f_r),
    .out_ctl (x_ctl),
    .out_n   (x_n),
    .out_acc (x_acc)
  );

  // Stage D: apply the integer shift and saturate
  logic               d_vld_r;
  logic [45:0]        d_pw_r;
  logic [45:0]        d_pw_nxt;
  logic [45:0]        d_sh;
  logic signed [11:0] d_nm;

  assign d_nm = -x_n;

  always_comb begin
    if (x_n >= 12'sd15) begin
      d_sh = GCB_P_LIMIT;
    end else if (x_n >= 12'sd0) begin
      d_sh = 46'(x_acc) << x_n[3:0];
    end else if (x_n > -12'sd32) begin
      d_sh = 46'(x_acc >> d_nm[4:0]);
    end else begin
      d_sh = '0;
    end
    if (x_ctl.zero) begin
      d_pw_nxt = '0;
    end else if (d_sh > GCB_P_LIMIT) begin
      d_pw_nxt = GCB_P_LIMIT;
    end else begin
      d_pw_nxt = d_sh;
    end
  end

  // Stage E: contrast scale and brightness offset in Q.42
  logic               e_vld_r;
  logic signed [63:0] e_v_r;
  logic signed [14:0] e_cplus;
  logic signed [61:0] e_vp;

  assign e_cplus = 15'(contrast_r) + 15'sd4096;
  assign e_vp    = signed'({1'b0, d_pw_r}) * e_cplus;

  // Stage F: classify and rescale by the maximum
  logic        f_vld_r;
  logic        f_le0_r;
  logic        f_ge1_r;
  logic [45:0] f_prod_r;

  // Stage G: round half to even, clamp, register out
  logic [15:0]            g_q;
  logic [29:0]            g_r;
  logic                   g_inc;
  logic [16:0]            g_q1;
  logic [15:0]            g_qc;
  logic [SAMPLE_BITS-1:0] g_res;
  logic                   out_strobe_r;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  assign g_q   = f_prod_r[45:30];
  assign g_r   = f_prod_r[29:0];
  assign g_inc = (g_r > 30'h2000_0000) || ((g_r == 30'h2000_0000) && g_q[0]);
  assign g_q1  = 17'(g_q) + 17'(g_inc);
  assign g_qc  = (g_q1 > 17'(max_r)) ? max_r : g_q1[15:0];

  always_comb begin
    if (max_r == '0 || f_le0_r) begin
      g_res = '0;
    end else if (f_ge1_r) begin
      g_res = SAMPLE_BITS'(max_r);
    end else begin
      g_res = SAMPLE_BITS'(g_qc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r      <= 1'b0;
      e_vld_r      <= 1'b0;
      f_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      d_vld_r      <= x_ctl.vld;
      e_vld_r      <= d_vld_r;
      f_vld_r      <= e_vld_r;
      out_strobe_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_pw_r       <= d_pw_nxt;
    e_v_r        <= 64'(e_vp) + (64'(bright_r) <<< 30);
    f_le0_r      <= e_v_r <= 64'sd0;
    f_ge1_r      <= e_v_r >= GCB_V_ONE;
    f_prod_r     <= 46'(e_v_r[41:12]) * 46'(max_r);
    out_sample_r <= g_res;
  end

  assign out_strobe     = out_strobe_r;
  assign out_sample_out = out_sample_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gcb_checker.sv =====
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks of latency, result bounds and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gamma_contrast_brightness_unit_defines.svh"

module gcb_checker import gcb_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_strobe,
  input wire logic [SAMPLE_BITS-1:0] out_sample_out,
  input wire logic                   cfg_we,
  input wire logic [1:0]             cfg_index,
  input wire logic [15:0]            cfg_data
);

  // Track the configured maximum as seen on the port
  logic [15:0] mx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mx_r <= 16'd255;
    end else if (cfg_we && cfg_index == GCB_REG_MAXIMUM) begin
      mx_r <= cfg_data;
    end
  end

  `GCB_ASSERT(a_beat_returns, (start && !busy) |-> ##GCB_LATENCY out_strobe)
  `GCB_ASSERT(a_no_stray_result, out_strobe |-> $past(start && !busy, GCB_LATENCY))
  `GCB_ASSERT(a_within_max, out_strobe |-> (33'(out_sample_out) <= 33'(mx_r)))
  `GCB_ASSERT_ALWAYS(a_busy_in_reset, busy == !rst_n)

endmodule

bind gamma_contrast_brightness_unit gcb_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_gcb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_sample_out (out_sample_out),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index),
  .cfg_data       (cfg_data)
);

`default_nettype wire

// ===== bench/tb_gamma_contrast_brightness_unit.sv =====
// ----------------------------------------------------------------------------
// tb_gamma_contrast_brightness_unit
// Self-checking bench for the gamma, contrast and brightness unit. Samples
// are streamed through under several register settings, and every output
// beat is checked against a fixed-point prediction kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gamma_contrast_brightness_unit import gcb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB        = 16;
  localparam int IDLE_WAIT = 80;
  localparam int WD_LIMIT  = 5000;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [SB-1:0] in_sample_in;
  logic          out_strobe;
  logic [SB-1:0] out_sample_out;
  logic          cfg_we;
  gcb_reg_t      cfg_index;
  logic [15:0]   cfg_data;

  gamma_contrast_brightness_unit #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_in(in_sample_in), .out_strobe(out_strobe),
    .out_sample_out(out_sample_out), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bench copy of the registers
  logic [15:0]        gam_q;
  logic signed [13:0] con_q;
  logic signed [13:0] bri_q;
  logic [15:0]        max_q;

  logic [63:0] roots [0:24];

  logic [SB-1:0] pending_samples [$];
  logic [SB-1:0] expected_samples [$];
  int  errors;
  int  sent;
  int  checked;
  int  quiet_cycles;
  int  send_idle_pct;
  bit  hold_send;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2 of a nonzero integer in Q.24, mantissa squaring
  function automatic logic [63:0] log2_fix(input logic [63:0] v);
    logic [63:0] e;
    logic [63:0] z;
    logic [63:0] fr;
    e = 0;
    fr = 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    z = v << (31 - e);
    for (int i = 0; i < 24; i++) begin
      z = (z * z) >> 31;
      fr = fr << 1;
      if (z >= 64'h1_0000_0000) begin
        fr[0] = 1'b1;
        z = z >> 1;
      end
    end
    return (e << 24) | fr;
  endfunction

  // Predict the adjusted sample under the current register copy
  function automatic logic [SB-1:0] adjusted_sample(input logic [SB-1:0] s);
    logic [63:0] m;
    logic [63:0] pw;
    logic [63:0] ls;
    logic [63:0] lm;
    logic [63:0] d;
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] r;
    longint      n;
    longint      v;
    bit          up;
    m = max_q;
    pw = 0;
    if (m == 0) return '0;
    if (s != 0) begin
      ls = log2_fix(s);
      lm = log2_fix(m);
      up = ls > lm;
      d = up ? ls - lm : lm - ls;
      p = (d * gam_q + 2048) >> 12;
      if (up) begin
        n = longint'(p >> 24);
        f = p & 64'hFF_FFFF;
      end else if ((p & 64'hFF_FFFF) == 0) begin
        n = -longint'(p >> 24);
        f = 0;
      end else begin
        n = -longint'(p >> 24) - 1;
        f = 64'h100_0000 - (p & 64'hFF_FFFF);
      end
      acc = 64'h4000_0000;
      for (int k = 1; k <= 24; k++)
        if (f[24-k]) acc = (acc * roots[k]) >> 30;
      if (n >= 15) pw = 64'h2000_0000_0000;
      else if (n >= 0) pw = acc << n;
      else if (n > -32) pw = acc >> (-n);
      else pw = 0;
      if (pw > 64'h2000_0000_0000) pw = 64'h2000_0000_0000;
    end
    v = longint'(pw) * (4096 + longint'(con_q)) + longint'(bri_q) * (64'sd1 <<< 30);
    if (v <= 0) return '0;
    if (v >= (64'sd1 <<< 42)) return m[SB-1:0];
    prod = (64'(v) >> 12) * m;
    q = prod >> 30;
    r = prod & 64'h3FFF_FFFF;
    if (r > 64'h2000_0000 || (r == 64'h2000_0000 && q[0])) q++;
    if (q > m) q = m;
    return q[SB-1:0];
  endfunction

  // Driver: offer the next pending sample, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_samples.push_back(adjusted_sample(in_sample_in));
        sent++;
      end
      if ((start && busy) ||
          (pending_samples.size() != 0 && !hold_send &&
           $urandom_range(99) >= send_idle_pct)) begin
        if (!(start && busy)) in_sample_in <= pending_samples.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles <= ((start && !busy) || out_strobe) ? 0 : quiet_cycles + 1;
      if (out_strobe) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected beat: sample_out actual %0d", out_sample_out);
          errors++;
        end else begin
          if (out_sample_out !== expected_samples[0]) begin
            $error("sample_out mismatch: expected %0d actual %0d",
                   expected_samples[0], out_sample_out);
            errors++;
          end
          void'(expected_samples.pop_front());
          checked++;
        end
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("watchdog expired");
        $display("[gamma_contrast_brightness_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || start || expected_samples.size() != 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // Present one register write for a cycle; the caller drops the enable
  task automatic write_reg(input gcb_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      GCB_REG_GAMMA:    gam_q = val;
      GCB_REG_CONTRAST: con_q = val[13:0];
      GCB_REG_BRIGHT:   bri_q = val[13:0];
      default:          max_q = val;
    endcase
  endtask

  task automatic set_all(input logic [15:0] g, input int c, input int b,
                         input logic [15:0] m);
    write_reg(GCB_REG_GAMMA, g);
    write_reg(GCB_REG_CONTRAST, 16'(c));
    write_reg(GCB_REG_BRIGHT, 16'(b));
    write_reg(GCB_REG_MAXIMUM, m);
    cfg_we <= 1'b0;
  endtask

  // Random samples, mostly in 0..max, some at 0 or max and some full range
  task automatic queue_random(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 75) pending_samples.push_back(SB'($urandom_range(max_q)));
      else if (sel < 85) pending_samples.push_back(sel[0] ? '0 : max_q);
      else pending_samples.push_back(SB'($urandom));
    end
  endtask

  initial begin
    logic [15:0] gl [0:5];
    logic [15:0] ml [0:5];
    int          cl [0:4];
    rst_n = 1'b0;
    start = 1'b0;
    in_sample_in = '0;
    cfg_we = 1'b0;
    cfg_index = GCB_REG_GAMMA;
    cfg_data = '0;
    errors = 0;
    sent = 0;
    checked = 0;
    quiet_cycles = 0;
    send_idle_pct = 11;
    hold_send = 1'b0;
    gam_q = 16'd4096;
    con_q = '0;
    bri_q = '0;
    max_q = 16'd255;
    roots[0] = 64'h8000_0000;
    for (int k = 1; k <= 24; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, sample extremes and above the maximum
    foreach (gl[i]) gl[i] = 16'd0;
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'd1);
    pending_samples.push_back(16'd128);
    pending_samples.push_back(16'd255);
    pending_samples.push_back(16'd256);
    pending_samples.push_back(16'hFFFF);
    pending_samples.push_back(16'h5555);
    pending_samples.push_back(16'hAAAA);
    wait_drained();
    // Zero gamma, brightness extremes, zero maximum, out-of-range adjusts
    set_all(16'd0, 0, 0, 16'd1000);
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'd7);
    pending_samples.push_back(16'd1000);
    wait_drained();
    set_all(16'd2048, -4096, 4096, 16'hFFFF);
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'hFFFF);
    wait_drained();
    set_all(16'd8192, 4096, -4096, 16'hFFFF);
    pending_samples.push_back(16'd1);
    pending_samples.push_back(16'h8000);
    pending_samples.push_back(16'hFFFF);
    wait_drained();
    set_all(16'hFFFF, 8191, -8192, 16'd0);
    pending_samples.push_back(16'd3);
    pending_samples.push_back(16'hFFFF);
    wait_drained();
    set_all(16'd1, -8192, 8191, 16'd1);
    pending_samples.push_back(16'd0);
    pending_samples.push_back(16'd1);
    pending_samples.push_back(16'd2);
    wait_drained();

    // Random phases over a grid of settings with random adjusts
    gl = '{16'd1, 16'd2048, 16'd4096, 16'd9011, 16'hFFFF, 16'd0};
    ml = '{16'd1, 16'd255, 16'd1023, 16'd4095, 16'hFFFF, 16'd0};
    cl = '{-4096, 0, 4096, -8192, 8191};
    for (int ph = 0; ph < 18; ph++) begin
      send_idle_pct = (ph < 6) ? 11 : (ph < 12) ? 54 : 0;
      set_all(ph % 3 == 0 ? gl[ph % 6] : 16'($urandom_range(1, 65535)),
              ph % 2 == 0 ? cl[ph % 5] : $urandom_range(0, 8192) - 4096,
              ph % 4 == 1 ? cl[(ph + 2) % 5] : $urandom_range(0, 8192) - 4096,
              ph % 5 == 4 ? 16'($urandom_range(1, 65535)) : ml[ph % 6]);
      queue_random(25);
      // Hold the sender until all outstanding results are in
      while (pending_samples.size() != 0 || start) @(posedge clk);
      hold_send = 1'b1;
      while (expected_samples.size() != 0) @(posedge clk);
      hold_send = 1'b0;
      queue_random(24);
      wait_drained();
    end

    $display("covered %0d samples, %0d checked, over 24 register settings", sent, checked);
    $display("including zero gamma, zero maximum and full-scale adjusts");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("[gamma_contrast_brightness_unit] OK");
    end else begin
      $display("[gamma_contrast_brightness_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
